### rtl/two_sat_scc_solver_defines.svh
// Assertion macros for the 2-SAT solver.
`ifndef TWO_SAT_SCC_SOLVER_DEFINES_SVH
`define TWO_SAT_SCC_SOLVER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TSS_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("%m");
`define TSS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("%m");
`else
`define TSS_ASSERT_IMP(label, clk, rst, a, c)
`define TSS_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### rtl/tss_pkg.sv
package tss_pkg;
  localparam int MaxVars = 32;
  localparam int NodeW = 6;
  localparam int MaxNodes = 64;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b000000000001,
    ST_CLEAR  = 12'b000000000010,
    ST_F_SEL  = 12'b000000000100,
    ST_F_RD   = 12'b000000001000,
    ST_F_STEP = 12'b000000010000,
    ST_R_SEL  = 12'b000000100000,
    ST_R_RD   = 12'b000001000000,
    ST_R_STEP = 12'b000010000000,
    ST_CHK    = 12'b000100000000,
    ST_CHK_RD = 12'b001000000000,
    ST_EMIT   = 12'b010000000000,
    ST_UNSAT  = 12'b100000000000
  } state_t;

  typedef struct packed {
    logic load_edge;   // write request edge into matrices
    logic clr_row;     // clear matrix row at clear counter
    logic clr_vis;     // clear all visited marks
    logic scan_init;   // zero node scan counter
    logic scan_inc;    // advance node scan
    logic f_push_start;// forward: mark and push scan node
    logic r_pop_start; // reverse: pop finish stack, start walk if unvisited
    logic rd_row;      // read row of walk-stack top
    logic step;        // advance walk one step (push or pop)
    logic comp_inc;    // advance component number
    logic chk_rd;      // read component numbers for var at scan counter
    logic chk_eval;    // evaluate satisfiability of read pair
    logic emit;        // strobe one result
    logic emit_unsat;  // strobe the unsatisfiable result
    logic rev;         // reverse pass selected
  } cmd_t;

  typedef struct packed {
    logic clr_last;    // clear counter on last row
    logic scan_done;   // scan counter past last node
    logic scan_vis;    // scan node already visited
    logic walk_empty;  // walk stack empties on this step
    logic fin_empty;   // finish stack empty
    logic pop_vis;     // node on finish stack top already visited
    logic var_last;    // scan counter on last variable
    logic sat;         // no conflict seen so far
  } stat_t;
endpackage

### rtl/two_sat_scc_solver.sv
// 2-SAT solver: implications load one request per cycle (busy stays low while loading).
// After the request marked end_of_clauses: forward then reverse DFS, each pass made of
// node selects, then a row read and a step per walk move; a check of every variable,
// then one result per variable or the single unsatisfiable one. No stall.
// Reset (rst, synchronous) runs a clear of all 64 matrix rows, busy high; also run after each solve.
module two_sat_scc_solver #(
  parameter int N_VARS = tss_pkg::MaxVars
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       has_edge,
  input  logic [4:0] from_var,
  input  logic       from_neg,
  input  logic [4:0] to_var,
  input  logic       to_neg,
  input  logic       end_of_clauses,
  output logic       strobe,
  output logic       satisfiable,
  output logic [4:0] var_index,
  output logic       value,
  output logic       final_result
);
  tss_pkg::cmd_t  cmd;
  tss_pkg::stat_t stat;

  // controller sequences clear, both DFS passes, the check and the output
  tss_ctrl u_ctrl (
    .clk, .rst, .start, .has_edge, .end_of_clauses, .busy, .cmd, .stat
  );

  // datapath holds adjacency matrices, stacks and component numbers
  tss_datapath #(.N_VARS(N_VARS)) u_dp (
    .clk, .rst, .cmd, .stat, .from_var, .from_neg, .to_var, .to_neg,
    .strobe, .satisfiable, .var_index, .value, .final_result
  );
endmodule

### rtl/tss_ctrl.sv
`include "two_sat_scc_solver_defines.svh"
module tss_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           has_edge,
  input  logic           end_of_clauses,
  output logic           busy,
  output tss_pkg::cmd_t  cmd,
  input  tss_pkg::stat_t stat
);
  tss_pkg::state_t state, state_next;

  // Reset starts a clear of the adjacency rows before any request.
  always_ff @(posedge clk) begin
    if (rst) state <= tss_pkg::ST_CLEAR;
    else state <= state_next;
  end

  assign busy = (state != tss_pkg::ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      tss_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load_edge = has_edge;
          if (end_of_clauses) begin
            cmd.scan_init = 1'b1;
            state_next = tss_pkg::ST_F_SEL;
          end
        end
      end
      tss_pkg::ST_CLEAR: begin
        cmd.clr_row = 1'b1;
        cmd.clr_vis = 1'b1;
        cmd.scan_init = 1'b1;
        if (stat.clr_last) state_next = tss_pkg::ST_IDLE;
      end
      tss_pkg::ST_F_SEL: begin
        if (stat.scan_done) begin
          cmd.clr_vis = 1'b1;
          state_next = tss_pkg::ST_R_SEL;
        end else if (stat.scan_vis) begin
          cmd.scan_inc = 1'b1;
        end else begin
          cmd.f_push_start = 1'b1;
          cmd.scan_inc = 1'b1;
          state_next = tss_pkg::ST_F_RD;
        end
      end
      tss_pkg::ST_F_RD: begin
        cmd.rd_row = 1'b1;
        state_next = tss_pkg::ST_F_STEP;
      end
      tss_pkg::ST_F_STEP: begin
        cmd.step = 1'b1;
        state_next = tss_pkg::ST_F_RD;
        if (stat.walk_empty) state_next = tss_pkg::ST_F_SEL;
      end
      tss_pkg::ST_R_SEL: begin
        cmd.rev = 1'b1;
        if (stat.fin_empty) begin
          cmd.scan_init = 1'b1;
          state_next = tss_pkg::ST_CHK;
        end else begin
          cmd.r_pop_start = 1'b1;
          if (!stat.pop_vis) state_next = tss_pkg::ST_R_RD;
        end
      end
      tss_pkg::ST_R_RD: begin
        cmd.rev = 1'b1;
        cmd.rd_row = 1'b1;
        state_next = tss_pkg::ST_R_STEP;
      end
      tss_pkg::ST_R_STEP: begin
        cmd.rev = 1'b1;
        cmd.step = 1'b1;
        state_next = tss_pkg::ST_R_RD;
        if (stat.walk_empty) begin
          cmd.comp_inc = 1'b1;
          state_next = tss_pkg::ST_R_SEL;
        end
      end
      tss_pkg::ST_CHK: begin
        cmd.chk_rd = 1'b1;
        state_next = tss_pkg::ST_CHK_RD;
      end
      tss_pkg::ST_CHK_RD: begin
        cmd.chk_eval = 1'b1;
        if (stat.var_last) begin
          state_next = tss_pkg::ST_EMIT;
        end else begin
          cmd.scan_inc = 1'b1;
          state_next = tss_pkg::ST_CHK;
        end
      end
      tss_pkg::ST_EMIT: begin
        // sat flag is final here; the last check evaluation rewound the counter
        if (!stat.sat) begin
          state_next = tss_pkg::ST_UNSAT;
        end else begin
          cmd.emit = 1'b1;
          if (stat.var_last) begin
            cmd.scan_init = 1'b1;
            state_next = tss_pkg::ST_CLEAR;
          end else cmd.scan_inc = 1'b1;
        end
      end
      tss_pkg::ST_UNSAT: begin
        cmd.emit_unsat = 1'b1;
        cmd.scan_init = 1'b1;
        state_next = tss_pkg::ST_CLEAR;
      end
      default: state_next = tss_pkg::ST_IDLE;
    endcase
  end

  `TSS_ASSERT_IMP(a_onehot, clk, rst, 1'b1, $onehot(state))
  `TSS_ASSERT_IMP(a_busy_solve, clk, rst, state != tss_pkg::ST_IDLE, busy)
  `TSS_ASSERT_NEXT(a_emit_clear, clk, rst, cmd.emit_unsat, state == tss_pkg::ST_CLEAR)
endmodule

### rtl/tss_datapath.sv
`include "two_sat_scc_solver_defines.svh"
module tss_datapath #(
  parameter int N_VARS = tss_pkg::MaxVars
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tss_pkg::cmd_t               cmd,
  output tss_pkg::stat_t              stat,
  input  logic [4:0]                  from_var,
  input  logic                        from_neg,
  input  logic [4:0]                  to_var,
  input  logic                        to_neg,
  output logic                        strobe,
  output logic                        satisfiable,
  output logic [4:0]                  var_index,
  output logic                        value,
  output logic                        final_result
);
  localparam int NW = tss_pkg::NodeW;
  localparam int NN = tss_pkg::MaxNodes;
  localparam logic [NW:0] NODES = 7'(2 * N_VARS);
  localparam logic [NW-1:0] NV = NW'(N_VARS);

  logic [NN-1:0] fwd_mem [NN];
  logic [NN-1:0] rev_mem [NN];
  logic [NW-1:0] fin_mem [NN];
  logic [NW-1:0] walk_mem [NN];
  logic [6:0]    comp_mem [NN];
  logic [6:0]    comp_a, comp_b;

  logic [NN-1:0] visited;
  logic [NW:0]   scan;
  logic [NW:0]   fin_cnt;
  logic [NW:0]   sp;
  logic [NW-1:0] top;     // walk stack top kept in a register
  logic [NN-1:0] row;
  logic [6:0]    comp;
  logic          sat;

  // node numbering: var, var + N_VARS for negated
  logic [NW-1:0] u, v, nu, nv;
  logic          in_range;
  assign in_range = ({1'b0, from_var} < 6'(N_VARS)) && ({1'b0, to_var} < 6'(N_VARS));
  assign u  = NW'(from_var) + (from_neg ? NV : '0);
  assign v  = NW'(to_var) + (to_neg ? NV : '0);
  assign nu = NW'(from_var) + (from_neg ? '0 : NV);
  assign nv = NW'(to_var) + (to_neg ? '0 : NV);

  // Edge load: row u gets v, row nv gets nu (forward); transposed in reverse.
  // Two rows change per matrix, so each matrix is split into
  // a read-modify-free OR on both rows through per-row write enables.
  always_ff @(posedge clk) begin
    if (cmd.clr_row) begin
      fwd_mem[scan[NW-1:0]] <= '0;
      rev_mem[scan[NW-1:0]] <= '0;
    end else if (cmd.load_edge && in_range) begin
      fwd_mem[u][v]   <= 1'b1;
      fwd_mem[nv][nu] <= 1'b1;
      rev_mem[v][u]   <= 1'b1;
      rev_mem[nu][nv] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_row) row <= cmd.rev ? rev_mem[top] : fwd_mem[top];
  end

  logic [NN-1:0] cand, cand_low;
  logic [NW-1:0] nx;
  logic [NN-1:0] node_mask;
  always_comb begin
    for (int i = 0; i < NN; i++) node_mask[i] = (i < 2 * N_VARS);
  end
  assign cand = row & ~visited & node_mask;
  assign cand_low = cand & (~cand + NN'(1));
  always_comb begin
    nx = '0;
    for (int i = 0; i < NN; i++) if (cand_low[i]) nx = nx | NW'(i);
  end

  // finish stack top, read one entry ahead: a pop fetches the entry below
  logic [NW-1:0] pop_node;
  logic [NW-1:0] fin_rd;
  assign fin_rd = fin_cnt[NW-1:0] - (cmd.r_pop_start ? NW'(2) : NW'(1));
  always_ff @(posedge clk) begin
    pop_node <= fin_mem[fin_rd];
  end

  always_ff @(posedge clk) begin
    if (cmd.f_push_start) walk_mem[0] <= scan[NW-1:0];
    else if (cmd.r_pop_start) walk_mem[0] <= pop_node;
    else if (cmd.step && cand != '0 && sp < 7'(NN)) walk_mem[sp[NW-1:0]] <= nx;
    if (cmd.step && cand == '0 && !cmd.rev) fin_mem[fin_cnt[NW-1:0]] <= top;
    if (cmd.r_pop_start && !visited[pop_node]) comp_mem[pop_node] <= comp;
    else if (cmd.step && cand != '0 && cmd.rev) comp_mem[nx] <= comp;
    if (cmd.chk_rd) begin
      comp_a <= comp_mem[scan[NW-1:0]];
      comp_b <= comp_mem[scan[NW-1:0] + NV];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      scan <= '0;
      fin_cnt <= '0;
      sp <= '0;
      comp <= 7'd1;
      sat <= 1'b1;
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit | cmd.emit_unsat;
      if (cmd.clr_vis) visited <= '0;
      if (cmd.scan_init && !cmd.clr_row) scan <= '0;
      else if (cmd.scan_inc || cmd.clr_row) scan <= scan + 7'd1;
      if (cmd.f_push_start) begin
        visited[scan[NW-1:0]] <= 1'b1;
        top <= scan[NW-1:0];
        sp <= 7'd1;
      end
      if (cmd.r_pop_start) begin
        fin_cnt <= fin_cnt - 7'd1;
        if (!visited[pop_node]) begin
          visited[pop_node] <= 1'b1;
          top <= pop_node;
          sp <= 7'd1;
        end
      end
      if (cmd.step) begin
        if (cand != '0) begin
          visited[nx] <= 1'b1;
          if (sp < 7'(NN)) begin
            sp <= sp + 7'd1;
            top <= nx;
          end
        end else begin
          if (!cmd.rev && fin_cnt < 7'(NN)) fin_cnt <= fin_cnt + 7'd1;
          sp <= sp - 7'd1;
          if (sp > 7'd1) top <= walk_mem[sp[NW-1:0] - NW'(2)];
        end
      end
      if (cmd.comp_inc) comp <= comp + 7'd1;
      if (cmd.chk_eval && comp_a == comp_b) sat <= 1'b0;
      if (cmd.emit_unsat || (cmd.emit && stat.var_last)) begin
        comp <= 7'd1;
        sat <= 1'b1;
        fin_cnt <= '0;
        visited <= '0;
      end
      if (cmd.chk_eval && stat.var_last) scan <= '0;
    end
  end

  // walk ends when the pop leaves the stack empty
  assign stat.walk_empty = (cand == '0) && (sp == 7'd1);
  assign stat.clr_last   = (scan[NW-1:0] == NW'(NN - 1));
  assign stat.scan_done  = (scan >= NODES);
  assign stat.scan_vis   = visited[scan[NW-1:0]];
  assign stat.fin_empty  = (fin_cnt == '0);
  assign stat.pop_vis    = visited[pop_node];
  assign stat.var_last   = (scan == 7'(N_VARS - 1));
  assign stat.sat        = sat;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      satisfiable  <= 1'b1;
      var_index    <= scan[4:0];
      value        <= comp_mem[scan[NW-1:0]] > comp_mem[scan[NW-1:0] + NV];
      final_result <= stat.var_last;
    end else if (cmd.emit_unsat) begin
      satisfiable  <= 1'b0;
      var_index    <= '0;
      value        <= 1'b0;
      final_result <= 1'b1;
    end
  end

  `TSS_ASSERT_IMP(a_sp_range, clk, rst, 1'b1, sp <= 7'(NN))
  `TSS_ASSERT_IMP(a_fin_range, clk, rst, 1'b1, fin_cnt <= 7'(NN))
  `TSS_ASSERT_NEXT(a_unsat_out, clk, rst, cmd.emit_unsat, strobe && !satisfiable)
endmodule
